@@ src/tbrle_pkg.sv @@
// Package for the threshold bilevel run-length encoder.
// Holds widths, reset values, register indexes and the result item type.
// Depends on nothing; all other files import it.
package tbrle_pkg;

   localparam int RUN_BITS      = 16;
   localparam int POSITION_BITS = 20;
   localparam int PIXEL_BITS    = 16;
   localparam int LEN_BITS      = 16;
   localparam int THRESH_BITS   = 16;
   localparam int FRAME_BITS    = 20;
   localparam int DATA_BITS     = 32;
   localparam int ADDR_BITS     = 3;

   localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(33808);
   localparam logic [FRAME_BITS-1:0]  FRAME_RESET  = FRAME_BITS'(400 * 240);

   localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

   localparam int CMP_BITS = (POSITION_BITS + 1 > FRAME_BITS) ? POSITION_BITS + 1 : FRAME_BITS;
   localparam int LEN_EXT_BITS = (RUN_BITS > LEN_BITS) ? RUN_BITS : LEN_BITS;

   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = 2;
   localparam int FIFO_CNT_BITS = 3;

   localparam logic [0:0] REG_THRESHOLD    = 1'b0;
   localparam logic [0:0] REG_FRAME_PIXELS = 1'b1;

   typedef struct packed {
      logic [LEN_BITS-1:0] run_length;
      logic                run_is_light;
      logic                frame_end;
      logic                item_last;
   } rsp_item_type;

   function automatic logic [LEN_BITS-1:0] to_len(input logic [RUN_BITS-1:0] run);
      logic [LEN_EXT_BITS-1:0] ext;
      ext = LEN_EXT_BITS'(run);
      return ext[LEN_BITS-1:0];
   endfunction

endpackage

@@ src/tbrle_req_if.sv @@
// Pixel channel of the bilevel run-length encoder: valid, ready and one pixel.
// Depends on tbrle_pkg.
interface tbrle_req_if import tbrle_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

@@ src/tbrle_rsp_if.sv @@
// Run channel of the bilevel run-length encoder: valid, ready and one run item.
// Depends on tbrle_pkg.
interface tbrle_rsp_if import tbrle_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [LEN_BITS-1:0] run_length;
   logic                run_is_light;
   logic                frame_end;
   logic                item_last;

   modport source (output valid, output run_length, output run_is_light,
                   output frame_end, output item_last, input ready);
   modport sink (input valid, input run_length, input run_is_light,
                 input frame_end, input item_last, output ready);
endinterface

@@ src/threshold_binary_run_length_encoder.sv @@
// Threshold bilevel run-length encoder, top level.
// Depends on tbrle_pkg, tbrle_req_if and tbrle_rsp_if.
//
// Usage:
//   req carries one pixel per item in scan order. Each pixel is light when it
//   is at or above the threshold register, else dark. rsp carries run items:
//   length, colour, frame_end on the last run of a frame, and item_last on the
//   last run caused by one pixel. A pixel yields zero, one or two runs.
//   Registers sit on the csr APB port: threshold at 0x0, frame_pixels
//   at 0x4. Write them only while the block is idle.
//   Throughput: one pixel per cycle while the queue has room. A pixel is
//   registered, then encoded into a four-entry result queue; encoding
//   proceeds while the queue holds at most two runs, so a pixel that yields
//   two runs costs one extra queue slot and throttles req only when runs pile up.
//   Path: an accepted pixel passes the input register and then the result
//   queue registers before any runs that it yields are offered on rsp.
//   Stall: when rsp is not taken the queue fills, the input register holds,
//   and req.ready drops; no item is lost.
//   Reset: registers return to 33808 and 96000, the encoder starts a new
//   frame in the dark phase, and the queue empties.
module threshold_binary_run_length_encoder import tbrle_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   tbrle_req_if.sink            req,
   tbrle_rsp_if.source          rsp,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready
);

   // configuration registers
   logic [THRESH_BITS-1:0] threshold_ff;
   logic [FRAME_BITS-1:0]  frame_ff;
   logic                   csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
         frame_ff     <= FRAME_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_THRESHOLD:    threshold_ff <= csr_pwdata[THRESH_BITS-1:0];
            REG_FRAME_PIXELS: frame_ff     <= csr_pwdata[FRAME_BITS-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_THRESHOLD:    csr_prdata = DATA_BITS'(threshold_ff);
         REG_FRAME_PIXELS: csr_prdata = DATA_BITS'(frame_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // input register
   logic                  stage_valid_ff;
   logic                  stage_valid_in;
   logic [PIXEL_BITS-1:0] pixel_ff;
   logic                  req_accept;
   logic                  fire;

   logic [FIFO_CNT_BITS-1:0] count_ff;
   logic [FIFO_CNT_BITS-1:0] count_in;

   assign fire           = stage_valid_ff & (count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
   assign req.ready      = ~stage_valid_ff | fire;
   assign req_accept     = req.valid & req.ready;
   assign stage_valid_in = req_accept | (stage_valid_ff & ~fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (req_accept) begin
         pixel_ff <= req.pixel;
      end
   end

   // encoder state and next-state logic
   logic                     phase_ff;
   logic                     phase_in;
   logic [RUN_BITS-1:0]      run_ff;
   logic [RUN_BITS-1:0]      run_in;
   logic [POSITION_BITS-1:0] pos_ff;
   logic [POSITION_BITS-1:0] pos_in;

   logic                     light;
   logic                     change;
   logic [RUN_BITS-1:0]      run_next;
   logic [POSITION_BITS:0]   pos_next;
   logic                     at_end;
   logic                     cap;
   logic                     second;
   rsp_item_type             item_change;
   rsp_item_type             item_second;

   assign light    = {1'b0, pixel_ff} >= {1'b0, threshold_ff};
   assign change   = light != phase_ff;
   assign run_next = (change ? '0 : run_ff) + RUN_BITS'(1);
   assign pos_next = {1'b0, pos_ff} + (POSITION_BITS + 1)'(1);
   assign at_end   = (CMP_BITS'(pos_next) >= CMP_BITS'(frame_ff)) | pos_next[POSITION_BITS];
   assign cap      = ~at_end & (run_next == RUN_MAX);
   assign second   = at_end | cap;

   always_comb begin
      item_change.run_length   = to_len(run_ff);
      item_change.run_is_light = phase_ff;
      item_change.frame_end    = 1'b0;
      item_change.item_last    = ~second;

      item_second.run_length   = to_len(run_next);
      item_second.run_is_light = light;
      item_second.frame_end    = at_end;
      item_second.item_last    = 1'b1;

      priority if (at_end) begin
         phase_in = 1'b0;
         run_in   = '0;
         pos_in   = '0;
      end else if (cap) begin
         phase_in = ~light;
         run_in   = '0;
         pos_in   = pos_next[POSITION_BITS-1:0];
      end else begin
         phase_in = light;
         run_in   = run_next;
         pos_in   = pos_next[POSITION_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         run_ff   <= '0;
         pos_ff   <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         run_ff   <= run_in;
         pos_ff   <= pos_in;
      end
   end

   // result queue
   rsp_item_type             queue_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ff;
   logic [FIFO_PTR_BITS-1:0] rd_ff;
   logic [FIFO_PTR_BITS-1:0] wr_second;
   logic [1:0]               push_count;
   logic                     pop;
   rsp_item_type             head;

   assign push_count = fire ? ({1'b0, change} + {1'b0, second}) : 2'd0;
   assign pop        = rsp.valid & rsp.ready;
   assign wr_second  = change ? wr_ff + FIFO_PTR_BITS'(1) : wr_ff;
   assign count_in   = count_ff + FIFO_CNT_BITS'(push_count) - FIFO_CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_ff + FIFO_PTR_BITS'(push_count);
         rd_ff    <= rd_ff + FIFO_PTR_BITS'(pop);
         count_ff <= count_in;
      end
      if (fire & change) begin
         queue_ff[wr_ff] <= item_change;
      end
      if (fire & second) begin
         queue_ff[wr_second] <= item_second;
      end
   end

   assign head             = queue_ff[rd_ff];
   assign rsp.valid        = count_ff != '0;
   assign rsp.run_length   = head.run_length;
   assign rsp.run_is_light = head.run_is_light;
   assign rsp.frame_end    = head.frame_end;
   assign rsp.item_last    = head.item_last;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH))
      else $error("result queue overflow");

   a_run_below_cap: assert property (@(posedge clock) disable iff (reset)
      run_ff != RUN_MAX)
      else $error("pending run reached the cap");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      fire & at_end |=> (run_ff == '0) && (pos_ff == '0) && !phase_ff)
      else $error("state not cleared after frame end");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      FIFO_PTR_BITS'(wr_ff - rd_ff) == count_ff[FIFO_PTR_BITS-1:0])
      else $error("queue pointers disagree with count");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      fire |=> count_ff <= $past(count_ff) + FIFO_CNT_BITS'(2))
      else $error("queue grew by more than two");

endmodule

@@ tb/threshold_binary_run_length_encoder_tb.sv @@
// Testbench for the threshold bilevel run-length encoder: random and directed pixels,
// run items checked in order against an in-bench encoder model, registers set over APB.
// Depends on tbrle_pkg, tbrle_req_if, tbrle_rsp_if and threshold_binary_run_length_encoder.
module threshold_binary_run_length_encoder_tb;
   import tbrle_pkg::*;

   localparam int CYCLE_LIMIT  = 500_000;
   localparam int PHASE_COUNT  = 12;
   localparam int PHASE_PIXELS = 100;
   localparam logic [FRAME_BITS-1:0] FRAME_MAX = {FRAME_BITS{1'b1}};

   class run_tracker;
      logic [THRESH_BITS-1:0]   thr;
      logic [FRAME_BITS-1:0]    frame_len;
      logic                     light_phase;
      logic [RUN_BITS-1:0]      run_len;
      logic [POSITION_BITS-1:0] pos_count;
      rsp_item_type             expected_runs[$];
      int errors;
      int n_pixels;
      int n_runs;
      int n_frame_ends;
      int n_capped;
      int n_pairs;
      int n_settings;

      function new();
         thr = THRESH_RESET;
         frame_len = FRAME_RESET;
         light_phase = 1'b0;
         run_len = '0;
         pos_count = '0;
         errors = 0;
         n_pixels = 0;
         n_runs = 0;
         n_frame_ends = 0;
         n_capped = 0;
         n_pairs = 0;
         n_settings = 0;
      endfunction

      function void fail(string msg);
         errors++;
         if (errors <= 10) begin
            $display("MISMATCH: %s", msg);
         end
      endfunction

      function void set_register(logic [0:0] idx, logic [DATA_BITS-1:0] data);
         n_settings++;
         if (idx == REG_THRESHOLD) begin
            thr = data[THRESH_BITS-1:0];
         end else begin
            frame_len = data[FRAME_BITS-1:0];
         end
      endfunction

      function int pending();
         return expected_runs.size();
      endfunction

      function void note_pixel(logic [PIXEL_BITS-1:0] pix);
         rsp_item_type          res[2];
         int                    n;
         logic                  light;
         logic [POSITION_BITS:0] next_pos;
         logic                  at_end;
         n = 0;
         n_pixels++;
         light = (pix >= thr);
         if (light != light_phase) begin
            res[n] = '{run_length: to_len(run_len), run_is_light: light_phase,
                       frame_end: 1'b0, item_last: 1'b0};
            n++;
            light_phase = light;
            run_len = '0;
         end
         run_len = run_len + RUN_BITS'(1);
         next_pos = {1'b0, pos_count} + (POSITION_BITS + 1)'(1);
         at_end = (next_pos >= {1'b0, frame_len}) || next_pos[POSITION_BITS];
         if (at_end) begin
            res[n] = '{run_length: to_len(run_len), run_is_light: light_phase,
                       frame_end: 1'b1, item_last: 1'b0};
            n++;
            light_phase = 1'b0;
            run_len = '0;
            pos_count = '0;
         end else begin
            pos_count = next_pos[POSITION_BITS-1:0];
            if (run_len == RUN_MAX) begin
               res[n] = '{run_length: to_len(run_len), run_is_light: light_phase,
                          frame_end: 1'b0, item_last: 1'b0};
               n++;
               light_phase = ~light_phase;
               run_len = '0;
            end
         end
         if (n > 0) begin
            res[n-1].item_last = 1'b1;
         end
         if (n == 2) begin
            n_pairs++;
         end
         for (int k = 0; k < n; k++) begin
            expected_runs.push_back(res[k]);
         end
      endfunction

      function void check_run(rsp_item_type got);
         rsp_item_type want;
         n_runs++;
         if (got.frame_end) begin
            n_frame_ends++;
         end
         if (got.run_length == RUN_MAX) begin
            n_capped++;
         end
         if (expected_runs.size() == 0) begin
            fail($sformatf("unexpected run len=%0d light=%0b end=%0b last=%0b",
                           got.run_length, got.run_is_light, got.frame_end, got.item_last));
            return;
         end
         want = expected_runs.pop_front();
         if (got.run_length !== want.run_length) begin
            fail($sformatf("run_length expected %0d actual %0d",
                           want.run_length, got.run_length));
         end
         if (got.run_is_light !== want.run_is_light) begin
            fail($sformatf("run_is_light expected %0b actual %0b",
                           want.run_is_light, got.run_is_light));
         end
         if (got.frame_end !== want.frame_end) begin
            fail($sformatf("frame_end expected %0b actual %0b",
                           want.frame_end, got.frame_end));
         end
         if (got.item_last !== want.item_last) begin
            fail($sformatf("item_last expected %0b actual %0b",
                           want.item_last, got.item_last));
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [ADDR_BITS-1:0] csr_paddr;
   logic [DATA_BITS-1:0] csr_pwdata;
   logic [DATA_BITS-1:0] csr_prdata;
   logic                 csr_pready;

   tbrle_req_if req_ch ();
   tbrle_rsp_if rsp_ch ();

   run_tracker sb;
   bit         req_gaps_on;
   bit         rsp_stalls_on;
   int         rsp_hold;
   int         cycles;

   threshold_binary_run_length_encoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   function automatic int pick_gap();
      if ($urandom_range(0, 19) == 0) begin
         return $urandom_range(10, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [PIXEL_BITS-1:0] pick_pixel(input logic light);
      if (light || sb.thr == 0) begin
         return PIXEL_BITS'($urandom_range(int'(sb.thr), 65535));
      end
      return PIXEL_BITS'($urandom_range(0, int'(sb.thr) - 1));
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d runs still expected", cycles, sb.pending());
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_run('{run_length: rsp_ch.run_length, run_is_light: rsp_ch.run_is_light,
                           frame_end: rsp_ch.frame_end, item_last: rsp_ch.item_last});
         end
         if (rsp_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold <= rsp_hold - 1;
         end else if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold <= pick_gap() - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix);
      req_ch.valid <= 1'b1;
      req_ch.pixel <= pix;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_pixel(pix);
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   // hold off until every run is out, then let the pipeline settle
   task automatic drain_runs();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [0:0] idx, input logic [DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_register(idx, data);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_check(input logic [0:0] idx);
      logic [DATA_BITS-1:0] want;
      want = (idx == REG_THRESHOLD) ? DATA_BITS'(sb.thr) : DATA_BITS'(sb.frame_len);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_BITS'({idx, 2'b00});
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== want) begin
         sb.fail($sformatf("register %0d expected %0h actual %0h", idx, want, csr_prdata));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_both(input logic [THRESH_BITS-1:0] t, input logic [FRAME_BITS-1:0] f);
      csr_write(REG_THRESHOLD, DATA_BITS'(t));
      csr_write(REG_FRAME_PIXELS, DATA_BITS'(f));
      csr_check(REG_THRESHOLD);
      csr_check(REG_FRAME_PIXELS);
   endtask

   task automatic send_run(input logic light, input int count);
      for (int k = 0; k < count; k++) begin
         send_pixel(pick_pixel(light));
      end
   endtask

   initial begin
      logic [THRESH_BITS-1:0] t;
      logic [FRAME_BITS-1:0]  f;
      int                     sent;
      int                     r;
      int                     len;
      int                     v;
      clock = 1'b0;
      reset = 1'b1;
      cycles = 0;
      rsp_hold = 0;
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.pixel = '0;
      rsp_ch.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_check(REG_THRESHOLD);
      csr_check(REG_FRAME_PIXELS);

      // field extremes, threshold edges, colour change meeting frame end
      set_both(16'h8000, 20'd8);
      send_pixel(16'h0000);
      send_pixel(16'hFFFF);
      send_pixel(16'h7FFF);
      send_pixel(16'h8000);
      send_pixel(16'h8000);
      send_pixel(16'h7FFF);
      send_pixel(16'hFFFF);
      send_pixel(16'h0000);
      drain_runs();
      set_both(16'h8000, 20'd1);
      send_pixel(16'hFFFF);
      send_pixel(16'h0000);
      drain_runs();
      set_both(16'h8000, 20'd0);
      send_pixel(16'h8000);
      send_pixel(16'h7FFF);
      drain_runs();
      set_both(16'h0000, 20'd3);
      send_pixel(16'h0000);
      send_pixel(16'h1234);
      send_pixel(16'hFFFF);
      drain_runs();
      set_both(16'hFFFF, 20'd3);
      send_pixel(16'hFFFE);
      send_pixel(16'hFFFF);
      send_pixel(16'h0000);
      drain_runs();

      // lower frame length below the current position mid-frame
      set_both(16'h8000, 20'd20);
      send_pixel(16'h0001);
      send_pixel(16'h0002);
      send_pixel(16'hC000);
      send_pixel(16'hC001);
      send_pixel(16'h0003);
      send_pixel(16'h0004);
      drain_runs();
      csr_write(REG_FRAME_PIXELS, DATA_BITS'(3));
      send_pixel(16'h9000);
      drain_runs();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         r = $urandom_range(0, 9);
         t = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : THRESH_BITS'($urandom);
         r = $urandom_range(0, 9);
         unique case (r)
            0: f = '0;
            1: f = FRAME_BITS'(1);
            2: f = FRAME_MAX;
            3: f = FRAME_BITS'($urandom_range(100, 3000));
            default: f = FRAME_BITS'($urandom_range(2, 40));
         endcase
         set_both(t, f);
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         sent = 0;
         while (sent < PHASE_PIXELS) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
               len = $urandom_range(1, 24);
               send_run(1'($urandom), len);
               sent += len;
            end else if (r < 9) begin
               v = int'(sb.thr) + $urandom_range(0, 4) - 2;
               v = (v < 0) ? 0 : (v > 65535) ? 65535 : v;
               send_pixel(PIXEL_BITS'(v));
               sent++;
            end else begin
               send_pixel(PIXEL_BITS'($urandom));
               sent++;
            end
         end
         drain_runs();
      end

      rsp_stalls_on = 1'b0;
      drain_runs();
      repeat (8) @(posedge clock);
      $display("Run covered %0d pixels and %0d runs over %0d register writes",
               sb.n_pixels, sb.n_runs, sb.n_settings);
      $display("Frame ends %0d, capped runs %0d, pixels with two runs %0d, cycles %0d",
               sb.n_frame_ends, sb.n_capped, sb.n_pairs, cycles);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d runs left over", sb.errors, sb.pending());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
